[hdl/fpba_pkg.sv]
// ----------------------------------------------------------------------------
// fpba_pkg: shared types and constants of the fit-policy block allocator
// Table geometry, field widths, mode and register codes, and the record that
// walks down the cell chain during a search.
// ----------------------------------------------------------------------------
package fpba_pkg;

  localparam int NUM_BLOCKS = 16;   // 2 .. 256
  localparam int SIZE_BITS  = 16;   // 8 .. 32

  localparam int IDX_W    = $clog2(NUM_BLOCKS);
  localparam int CMP_W    = 9;      // holds any index up to 256 and the 5-bit count
  localparam int EXT_W    = 48;

  // fixed field widths
  localparam int KIND_W   = 1;
  localparam int BIDX_W   = 4;
  localparam int FSIZE_W  = 16;
  localparam int MODE_W   = 2;
  localparam int COUNT_W  = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(16);

  localparam logic [KIND_W-1:0] KIND_LOAD    = 1'b0;
  localparam logic [KIND_W-1:0] KIND_REQUEST = 1'b1;

  localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'b1;

  typedef logic [SIZE_BITS-1:0] size_t;
  typedef logic [IDX_W-1:0]     idx_t;

  // best candidate seen so far
  typedef struct packed {
    logic  hit;
    idx_t  idx;
    size_t size;
  } cand_t;

  // search settings broadcast to every cell
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [COUNT_W-1:0] count;
    size_t              want;
  } scan_ctl_t;

  // per-cell table update
  typedef struct packed {
    logic  load_en;
    size_t load_size;
    logic  clr_en;
  } cell_wr_t;

  function automatic size_t to_size(input logic [FSIZE_W-1:0] v);
    logic [EXT_W-1:0] w;
    w = EXT_W'(v);
    return w[SIZE_BITS-1:0];
  endfunction

  function automatic logic [BIDX_W-1:0] to_chosen(input idx_t v);
    logic [CMP_W-1:0] w;
    w = CMP_W'(v);
    return w[BIDX_W-1:0];
  endfunction

endpackage

[hdl/fpba_if.sv]
// ----------------------------------------------------------------------------
// fpba_in_if / fpba_out_if: request and result channels
// Valid/ready channels carrying the load/request item and the allocation
// result.
// ----------------------------------------------------------------------------
interface fpba_in_if;
  logic                         valid;
  logic                         ready;
  logic [fpba_pkg::KIND_W-1:0]  kind;
  logic [fpba_pkg::BIDX_W-1:0]  block_index;
  logic [fpba_pkg::FSIZE_W-1:0] load_size;
  logic [fpba_pkg::FSIZE_W-1:0] request_size;
  logic                         last_request;

  modport source (output valid, kind, block_index, load_size, request_size,
                  last_request, input ready);
  modport sink   (input valid, kind, block_index, load_size, request_size,
                  last_request, output ready);
endinterface

interface fpba_out_if;
  logic                        valid;
  logic                        ready;
  logic                        allocated;
  logic [fpba_pkg::BIDX_W-1:0] chosen_block;
  logic                        batch_done;

  modport source (output valid, allocated, chosen_block, batch_done, input ready);
  modport sink   (input valid, allocated, chosen_block, batch_done, output ready);
endinterface

[hdl/fit_policy_block_allocator_top.sv]
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_top: first/best/worst fit block allocator
// Table of block sizes with free bits, searched by a chain of cells.
// ----------------------------------------------------------------------------
// A load item writes its entry straight into the cell that holds it. A request
// sends the search candidate down the cell chain one cell per clock; the finish
// state then reads the winner, frees nothing new but marks the winner used, and
// loads the result register once that register is free or being emptied. A new
// item can be accepted while a result waits in the output register; the next
// request finishes only once it is taken.
module fit_policy_block_allocator_top (
  input  logic                                clk,
  input  logic                                rst_n,
  fpba_in_if.sink                             in_ch,
  fpba_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [fpba_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fpba_pkg::CFG_DATA_W-1:0]     cfg_data
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_t;

  state_t                          state_r;
  fpba_pkg::idx_t                  cnt_r;
  logic [fpba_pkg::MODE_W-1:0]     fit_mode_r;
  logic [fpba_pkg::COUNT_W-1:0]    block_count_r;
  fpba_pkg::size_t                 want_r;
  logic                            last_r;
  logic                            out_valid_r;
  logic                            allocated_r;
  logic [fpba_pkg::BIDX_W-1:0]     chosen_r;
  logic                            batch_done_r;

  fpba_pkg::scan_ctl_t             ctl;
  fpba_pkg::cand_t                 cand_w [0:fpba_pkg::NUM_BLOCKS];
  fpba_pkg::cell_wr_t              wr_w   [0:fpba_pkg::NUM_BLOCKS-1];
  logic [fpba_pkg::NUM_BLOCKS-1:0] free_vec;
  fpba_pkg::cand_t                 result;

  logic in_acc, load_acc, req_acc, capture;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign load_acc    = in_acc && (in_ch.kind == fpba_pkg::KIND_LOAD);
  assign req_acc     = in_acc && (in_ch.kind == fpba_pkg::KIND_REQUEST);
  assign result      = cand_w[fpba_pkg::NUM_BLOCKS];
  assign capture     = (state_r == ST_FINISH) && (!out_valid_r || out_ch.ready);

  assign ctl.mode  = fit_mode_r;
  assign ctl.count = block_count_r;
  assign ctl.want  = want_r;

  assign cand_w[0] = '0;

  for (genvar g = 0; g < fpba_pkg::NUM_BLOCKS; g++) begin : g_cell
    always_comb begin
      wr_w[g].load_en   = load_acc &&
                          (fpba_pkg::CMP_W'(in_ch.block_index) == fpba_pkg::CMP_W'(g));
      wr_w[g].load_size = fpba_pkg::to_size(in_ch.load_size);
      wr_w[g].clr_en    = capture && result.hit &&
                          (result.idx == fpba_pkg::IDX_W'(g));
    end

    fpba_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (fpba_pkg::IDX_W'(g)),
      .ctl      (ctl),
      .wr       (wr_w[g]),
      .cand_in  (cand_w[g]),
      .cand_out (cand_w[g+1]),
      .free_o   (free_vec[g])
    );
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r    <= fpba_pkg::FIT_FIRST;
      block_count_r <= fpba_pkg::COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fpba_pkg::REG_FIT_MODE:    fit_mode_r    <= cfg_data[fpba_pkg::MODE_W-1:0];
        fpba_pkg::REG_BLOCK_COUNT: block_count_r <= cfg_data[fpba_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (req_acc) begin
      want_r <= fpba_pkg::to_size(in_ch.request_size);
      last_r <= in_ch.last_request;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (req_acc) begin
            state_r <= ST_SCAN;
            cnt_r   <= '0;
          end
        end
        ST_SCAN: begin
          // advance until the candidate leaves the last cell
          if (cnt_r == fpba_pkg::IDX_W'(fpba_pkg::NUM_BLOCKS - 1)) begin
            state_r <= ST_FINISH;
          end else begin
            cnt_r <= cnt_r + fpba_pkg::IDX_W'(1);
          end
        end
        ST_FINISH: begin
          if (capture) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase

      if (capture) begin
        out_valid_r  <= 1'b1;
        allocated_r  <= result.hit;
        chosen_r     <= result.hit ? fpba_pkg::to_chosen(result.idx) : '0;
        batch_done_r <= last_r;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.allocated    = allocated_r;
  assign out_ch.chosen_block = chosen_r;
  assign out_ch.batch_done   = batch_done_r;

  // a winning entry must be free and large enough
  a_win_free: assert property (@(posedge clk) disable iff (!rst_n)
    capture && result.hit |-> free_vec[result.idx] && (result.size >= want_r))
    else $error("winner is not a free fitting block");

  // the winner is marked used right after the result is captured
  a_win_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    capture && result.hit |=> !free_vec[$past(result.idx)])
    else $error("winner still free after allocation");

  // the table does not change while the candidate walks the chain
  a_scan_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |=> $stable(free_vec))
    else $error("free bits changed during a search");

  // a finished search cannot be lost while the result register is full
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH) && out_valid_r && !out_ch.ready |=> (state_r == ST_FINISH))
    else $error("search result dropped");

endmodule

[hdl/fpba_cell.sv]
// ----------------------------------------------------------------------------
// fpba_cell: one table entry of the allocator chain
// Holds one block size and its free bit, and each cycle passes the better of
// the incoming candidate and its own entry to the next cell.
// ----------------------------------------------------------------------------
module fpba_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  fpba_pkg::idx_t     cell_idx,
  input  fpba_pkg::scan_ctl_t ctl,
  input  fpba_pkg::cell_wr_t wr,
  input  fpba_pkg::cand_t    cand_in,
  output fpba_pkg::cand_t    cand_out,
  output logic               free_o
);

  fpba_pkg::size_t size_r;
  logic            free_r;
  fpba_pkg::cand_t cand_r, cand_nxt;
  logic            in_range, elig, better;

  always_comb begin
    in_range = fpba_pkg::CMP_W'(cell_idx) < fpba_pkg::CMP_W'(ctl.count);
    elig     = free_r && (size_r >= ctl.want) && in_range;
    priority if (!cand_in.hit) begin
      better = 1'b1;
    end else if (ctl.mode == fpba_pkg::FIT_BEST) begin
      better = size_r < cand_in.size;
    end else if (ctl.mode == fpba_pkg::FIT_WORST) begin
      better = size_r > cand_in.size;
    end else begin
      // first fit and the spare mode code: an earlier hit always wins
      better = 1'b0;
    end
    cand_nxt = cand_in;
    if (elig && better) begin
      cand_nxt.hit  = 1'b1;
      cand_nxt.idx  = cell_idx;
      cand_nxt.size = size_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r <= 1'b0;
    end else if (wr.load_en) begin
      free_r <= 1'b1;
    end else if (wr.clr_en) begin
      free_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.load_en) begin
      size_r <= wr.load_size;
    end
    cand_r <= cand_nxt;
  end

  assign cand_out = cand_r;
  assign free_o   = free_r;

endmodule

[tb/tb_fit_policy_block_allocator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fit_policy_block_allocator_top: self-checking bench of the block allocator
// Loads block sizes and sends allocation requests under first, best and worst
// fit, with random sender gaps and receiver stalls. A local copy of the table
// predicts each allocation; every result is checked against the oldest one.
// ----------------------------------------------------------------------------
module tb_fit_policy_block_allocator_top;

  localparam int          CLK_HALF       = 6;
  localparam int          TARGET_ITEMS   = 1700;
  localparam int          DRAIN_CYCLES   = fpba_pkg::NUM_BLOCKS + 8;
  localparam int          HOLDOFF_CYCLES = 400;
  localparam int          STALL_LIMIT    = 3000;
  localparam logic [fpba_pkg::MODE_W-1:0] FIT_SPARE = 2'd3;

  typedef struct packed {
    logic                        allocated;
    logic [fpba_pkg::BIDX_W-1:0] chosen_block;
    logic                        batch_done;
  } alloc_result_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [fpba_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [fpba_pkg::CFG_DATA_W-1:0] cfg_data;

  fpba_in_if  in_ch ();
  fpba_out_if out_ch ();

  fit_policy_block_allocator_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // local copy of the allocator state
  fpba_pkg::size_t              blk_size [fpba_pkg::NUM_BLOCKS];
  logic                         blk_free [fpba_pkg::NUM_BLOCKS];
  logic [fpba_pkg::MODE_W-1:0]  cur_mode;
  logic [fpba_pkg::COUNT_W-1:0] cur_count;

  alloc_result_t expected_allocs [$];
  int error_count      = 0;
  int quiet_cycles     = 0;
  int items_sent       = 0;
  int burst_left       = 0;
  int holdoff_requests = 0;
  bit gaps_enabled     = 1'b1;

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // Search the table for a request and mark the winner used.
  function automatic alloc_result_t search_table(input fpba_pkg::size_t need,
                                                 input logic last);
    int unsigned   span;
    int unsigned   pick;
    bit            found;
    alloc_result_t r;
    span  = (cur_count > fpba_pkg::NUM_BLOCKS) ? fpba_pkg::NUM_BLOCKS : cur_count;
    found = 1'b0;
    pick  = 0;
    for (int j = 0; j < span; j++) begin
      if (!blk_free[j] || blk_size[j] < need) continue;
      if (!found) begin
        found = 1'b1;
        pick  = j;
        if (cur_mode != fpba_pkg::FIT_BEST && cur_mode != fpba_pkg::FIT_WORST) break;
      end else if (cur_mode == fpba_pkg::FIT_BEST) begin
        if (blk_size[j] < blk_size[pick]) pick = j;
      end else if (cur_mode == fpba_pkg::FIT_WORST) begin
        if (blk_size[j] > blk_size[pick]) pick = j;
      end
    end
    if (found) blk_free[pick] = 1'b0;
    else pick = 0;
    r.allocated    = found;
    r.chosen_block = fpba_pkg::BIDX_W'(pick);
    r.batch_done   = last;
    return r;
  endfunction

  always @(posedge clk) begin : scoreboard
    alloc_result_t got;
    alloc_result_t want;
    logic          moved;
    if (!rst_n) begin
      for (int j = 0; j < fpba_pkg::NUM_BLOCKS; j++) begin
        blk_size[j] = '0;
        blk_free[j] = 1'b0;
      end
      cur_mode  = fpba_pkg::FIT_FIRST;
      cur_count = fpba_pkg::COUNT_RESET;
      quiet_cycles <= 0;
    end else begin
      moved = 1'b0;
      if (out_ch.valid && out_ch.ready) begin
        moved            = 1'b1;
        got.allocated    = out_ch.allocated;
        got.chosen_block = out_ch.chosen_block;
        got.batch_done   = out_ch.batch_done;
        if (expected_allocs.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d", $time,
                   got.allocated, got.chosen_block, got.batch_done);
        end else begin
          want = expected_allocs.pop_front();
          if (got.allocated !== want.allocated) begin
            error_count++;
            $display("%0t: allocated mismatch, expected %0d, actual %0d", $time,
                     want.allocated, got.allocated);
          end
          if (got.chosen_block !== want.chosen_block) begin
            error_count++;
            $display("%0t: chosen_block mismatch, expected %0d, actual %0d", $time,
                     want.chosen_block, got.chosen_block);
          end
          if (got.batch_done !== want.batch_done) begin
            error_count++;
            $display("%0t: batch_done mismatch, expected %0d, actual %0d", $time,
                     want.batch_done, got.batch_done);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        moved = 1'b1;
        if (in_ch.kind == fpba_pkg::KIND_LOAD) begin
          blk_size[in_ch.block_index] = fpba_pkg::SIZE_BITS'(in_ch.load_size);
          blk_free[in_ch.block_index] = 1'b1;
        end else begin
          expected_allocs.push_back(
            search_table(fpba_pkg::SIZE_BITS'(in_ch.request_size), in_ch.last_request));
        end
      end
      if (cfg_we) begin
        if (cfg_index == fpba_pkg::REG_FIT_MODE) cur_mode = cfg_data[fpba_pkg::MODE_W-1:0];
        else cur_count = cfg_data[fpba_pkg::COUNT_W-1:0];
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end
  end

  // Receiver: switch between stall styles, honor long hold-offs on demand.
  initial begin : result_sink
    int style;
    int style_left;
    int tick;
    int holdoff_left;
    int holdoff_served;
    out_ch.ready   = 1'b0;
    style          = 0;
    style_left     = 0;
    tick           = 0;
    holdoff_left   = 0;
    holdoff_served = 0;
    forever begin
      @(posedge clk);
      if (holdoff_served != holdoff_requests) begin
        holdoff_served = holdoff_requests;
        holdoff_left   = HOLDOFF_CYCLES;
      end
      if (style_left == 0) begin
        style      = $urandom_range(0, 3);
        style_left = $urandom_range(32, 256);
      end
      style_left--;
      tick++;
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (style)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 3) != 0);
          2: out_ch.ready <= 1'($urandom_range(0, 1));
          default: out_ch.ready <= ((tick % 7) < 2);
        endcase
      end
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= STALL_LIMIT);
    $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_item(input logic [fpba_pkg::KIND_W-1:0] kind,
                           input logic [fpba_pkg::BIDX_W-1:0] idx,
                           input logic [fpba_pkg::FSIZE_W-1:0] lsz,
                           input logic [fpba_pkg::FSIZE_W-1:0] rsz,
                           input logic last);
    int gap;
    if (gaps_enabled && burst_left == 0) begin
      gap        = $urandom_range(1, 10);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      // idle with junk on the payload
      in_ch.valid        <= 1'b0;
      in_ch.kind         <= fpba_pkg::KIND_W'($urandom);
      in_ch.block_index  <= fpba_pkg::BIDX_W'($urandom);
      in_ch.load_size    <= fpba_pkg::FSIZE_W'($urandom);
      in_ch.request_size <= fpba_pkg::FSIZE_W'($urandom);
      in_ch.last_request <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= kind;
    in_ch.block_index  <= idx;
    in_ch.load_size    <= lsz;
    in_ch.request_size <= rsz;
    in_ch.last_request <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic load_block(input int idx, input logic [fpba_pkg::FSIZE_W-1:0] lsz);
    send_item(fpba_pkg::KIND_LOAD, fpba_pkg::BIDX_W'(idx), lsz,
              fpba_pkg::FSIZE_W'($urandom), 1'($urandom));
  endtask

  task automatic request_block(input logic [fpba_pkg::FSIZE_W-1:0] rsz, input logic last);
    send_item(fpba_pkg::KIND_REQUEST, fpba_pkg::BIDX_W'($urandom),
              fpba_pkg::FSIZE_W'($urandom), rsz, last);
  endtask

  // Drop valid and wait until every result is back and the search chain is empty.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_allocs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [fpba_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fpba_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_empty_table();
    request_block('0, 1'b1);
  endtask

  task automatic test_first_fit();
    load_block(0, 16'd100);
    load_block(1, 16'd50);
    load_block(2, 16'd200);
    load_block(3, 16'd50);
    load_block(4, 16'd0);
    load_block(15, 16'hFFFF);
    request_block(16'd0, 1'b0);
    request_block(16'd60, 1'b0);
    request_block(16'hFFFF, 1'b1);
  endtask

  task automatic test_best_fit();
    settle();
    write_cfg(fpba_pkg::REG_FIT_MODE, fpba_pkg::CFG_DATA_W'(fpba_pkg::FIT_BEST));
    load_block(5, 16'd30);
    load_block(6, 16'd10);
    load_block(7, 16'd10);
    request_block(16'd10, 1'b0);
    request_block(16'd5, 1'b0);
    request_block(16'hFFFF, 1'b1);
  endtask

  task automatic test_worst_fit();
    settle();
    write_cfg(fpba_pkg::REG_FIT_MODE, fpba_pkg::CFG_DATA_W'(fpba_pkg::FIT_WORST));
    load_block(8, 16'd70);
    load_block(9, 16'd70);
    request_block(16'd1, 1'b0);
    request_block(16'd1, 1'b1);
  endtask

  task automatic test_spare_mode();
    settle();
    write_cfg(fpba_pkg::REG_FIT_MODE, fpba_pkg::CFG_DATA_W'(FIT_SPARE));
    request_block(16'd0, 1'b1);
  endtask

  task automatic test_block_count();
    settle();
    write_cfg(fpba_pkg::REG_BLOCK_COUNT, fpba_pkg::CFG_DATA_W'(0));
    request_block(16'd0, 1'b1);
    settle();
    write_cfg(fpba_pkg::REG_BLOCK_COUNT, fpba_pkg::CFG_DATA_W'(31));
    request_block(16'd0, 1'b0);
    settle();
    write_cfg(fpba_pkg::REG_BLOCK_COUNT, fpba_pkg::CFG_DATA_W'(1));
    load_block(0, 16'd5);
    request_block(16'd5, 1'b1);
    settle();
    write_cfg(fpba_pkg::REG_BLOCK_COUNT, fpba_pkg::CFG_DATA_W'(16));
    write_cfg(fpba_pkg::REG_FIT_MODE, fpba_pkg::CFG_DATA_W'(fpba_pkg::FIT_FIRST));
  endtask

  // Fill the table, then keep requesting while the receiver holds off.
  task automatic test_backpressure();
    settle();
    gaps_enabled = 1'b0;
    for (int j = 0; j < fpba_pkg::NUM_BLOCKS; j++)
      load_block(j, fpba_pkg::FSIZE_W'($urandom_range(0, 4000)));
    holdoff_requests++;
    repeat (12) request_block(fpba_pkg::FSIZE_W'($urandom_range(0, 3000)), 1'($urandom));
    settle();
    gaps_enabled = 1'b1;
  endtask

  task automatic test_random_traffic();
    logic [fpba_pkg::FSIZE_W-1:0] batch_sizes [fpba_pkg::NUM_BLOCKS];
    logic [fpba_pkg::FSIZE_W-1:0] sz;
    int nloads;
    int nreqs;
    int style;
    while (items_sent < TARGET_ITEMS) begin
      if ($urandom_range(0, 5) == 0) begin
        settle();
        write_cfg(fpba_pkg::REG_FIT_MODE,
                  ($urandom_range(0, 3) == 0) ? fpba_pkg::CFG_DATA_W'($urandom)
                                              : fpba_pkg::CFG_DATA_W'($urandom_range(0, 3)));
        if ($urandom_range(0, 1) == 0) begin
          case ($urandom_range(0, 5))
            0: write_cfg(fpba_pkg::REG_BLOCK_COUNT, fpba_pkg::CFG_DATA_W'(0));
            1: write_cfg(fpba_pkg::REG_BLOCK_COUNT, fpba_pkg::CFG_DATA_W'(1));
            2: write_cfg(fpba_pkg::REG_BLOCK_COUNT, fpba_pkg::CFG_DATA_W'(31));
            3: write_cfg(fpba_pkg::REG_BLOCK_COUNT,
                         fpba_pkg::CFG_DATA_W'($urandom_range(17, 30)));
            default: write_cfg(fpba_pkg::REG_BLOCK_COUNT,
                               fpba_pkg::CFG_DATA_W'($urandom_range(2, 16)));
          endcase
        end
        gaps_enabled = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 9) == 0) begin
        // noise: loose mix of loads and requests
        repeat ($urandom_range(1, 8))
          send_item(fpba_pkg::KIND_W'($urandom), fpba_pkg::BIDX_W'($urandom),
                    fpba_pkg::FSIZE_W'($urandom), fpba_pkg::FSIZE_W'($urandom),
                    1'($urandom));
      end else begin
        style  = $urandom_range(0, 2);
        nloads = $urandom_range(0, 12);
        for (int i = 0; i < nloads; i++) begin
          case (style)
            0: sz = fpba_pkg::FSIZE_W'($urandom);
            1: sz = fpba_pkg::FSIZE_W'($urandom_range(0, 7) * 8);
            default: sz = 16'hFFFF - fpba_pkg::FSIZE_W'($urandom_range(0, 7));
          endcase
          batch_sizes[i] = sz;
          load_block($urandom_range(0, fpba_pkg::NUM_BLOCKS - 1), sz);
        end
        nreqs = $urandom_range(1, 8);
        for (int r = 0; r < nreqs; r++) begin
          case ($urandom_range(0, 7))
            0: sz = '0;
            1: sz = 16'hFFFF;
            2: sz = fpba_pkg::FSIZE_W'($urandom);
            default: begin
              if (nloads > 0)
                sz = batch_sizes[$urandom_range(0, nloads - 1)]
                     + fpba_pkg::FSIZE_W'($urandom_range(0, 2)) - 16'd1;
              else
                sz = fpba_pkg::FSIZE_W'($urandom);
            end
          endcase
          request_block(sz, (r == nreqs - 1));
        end
      end
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.kind         = fpba_pkg::KIND_LOAD;
    in_ch.block_index  = '0;
    in_ch.load_size    = '0;
    in_ch.request_size = '0;
    in_ch.last_request = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_first_fit();
    test_best_fit();
    test_worst_fit();
    test_spare_mode();
    test_block_count();
    test_backpressure();
    test_random_traffic();
    settle();
    if (error_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
